FILE: design/gsa_pkg.sv
// gsa_pkg: word type, turn-domain constants and divisor tables for the
// greenwich sidereal angle pipeline; no dependencies
`timescale 1ns / 1ps

package gsa_pkg;

    typedef logic [63:0] word_t;

    // floor(num * 2^64 / den), num < den, evaluated at elaboration
    function automatic word_t frac_q64(input word_t num, input word_t den);
        logic [64:0] rem;
        word_t       quo;
        rem = {1'b0, num};
        quo = '0;
        for (int i = 0; i < 64; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // taylor term divisors, k = 1 .. 8
    function automatic logic [9:0] sin_div(input int k);
        return 10'((2 * k) * (2 * k + 1));
    endfunction

    function automatic logic [9:0] cos_div(input int k);
        return 10'((2 * k - 1) * (2 * k));
    endfunction

    localparam logic [31:0] J2000_DAY = 32'd2451545;
    localparam word_t PI_Q62  = 64'hC90FDAA22168C234;
    localparam word_t ONE_Q62 = 64'h4000000000000000;
    localparam word_t EIGHTH  = 64'h2000000000000000;

    localparam word_t K_T    = frac_q64(64'd1, 64'd36525);
    localparam word_t K_L0   = frac_q64(64'd2804665, 64'd3600000);
    localparam word_t K_LR   = frac_q64(64'd360007698, 64'd131490000000);
    localparam word_t K_LP0  = frac_q64(64'd2183165, 64'd3600000);
    localparam word_t K_LPR  = frac_q64(64'd4812678813, 64'd131490000000);
    localparam word_t K_N0   = frac_q64(64'd12504452, 64'd36000000);
    localparam word_t K_NR   = frac_q64(64'd1934136261, 64'd13149000000000);

    localparam word_t C_DPSI0 = frac_q64(64'd172, 64'd12960000);
    localparam word_t C_DEPS0 = frac_q64(64'd92, 64'd12960000);
    localparam word_t C_DPSI1 = frac_q64(64'd132, 64'd129600000);
    localparam word_t C_DEPS1 = frac_q64(64'd57, 64'd129600000);
    localparam word_t C_DPSI2 = frac_q64(64'd23, 64'd129600000);
    localparam word_t C_DEPS2 = frac_q64(64'd1, 64'd12960000);
    localparam word_t C_DPSI3 = frac_q64(64'd21, 64'd129600000);
    localparam word_t C_DEPS3 = frac_q64(64'd9, 64'd129600000);

    localparam word_t K_E0 = frac_q64(64'd84381448, 64'd1296000000);
    localparam word_t K_E1 = frac_q64(64'd46815, 64'd1296000000);
    localparam word_t K_E2 = frac_q64(64'd59, 64'd129600000000);
    localparam word_t K_E3 = frac_q64(64'd1813, 64'd1296000000000);

    localparam word_t K_G0 = frac_q64(64'd28046061837, 64'd36000000000);
    localparam word_t K_GR = frac_q64(64'd98564736629, 64'd36000000000000);
    localparam word_t K_G2 = frac_q64(64'd387933, 64'd360000000000);
    localparam word_t K_G3 = frac_q64(64'd1, 64'd13935600000000);

endpackage

FILE: design/gsa_mul.sv
// gsa_mul: three-stage 64x64 multiply from 33-bit partial products,
// floor shift and 64-bit slice; carries a side word; uses gsa_pkg
`timescale 1ns / 1ps

module gsa_mul #(
    parameter bit A_SIGNED = 1'b0,
    parameter bit B_SIGNED = 1'b0,
    parameter int SHIFT    = 0,
    parameter int SIDE_W   = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  gsa_pkg::word_t        a,
    input  gsa_pkg::word_t        b,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output gsa_pkg::word_t        p,
    output logic [SIDE_W-1:0]     side_out
);

    logic signed [32:0] ah, al, bh, bl;
    logic signed [65:0] hh_next, hl_next, lh_next;
    logic [63:0]        ll_next;

    logic signed [65:0] hh1_reg, hl1_reg, lh1_reg;
    logic [63:0]        ll1_reg;
    logic signed [65:0] hh2_reg;
    logic signed [66:0] mid2_reg;
    logic [63:0]        ll2_reg;
    logic [127:0]       sum_next;
    gsa_pkg::word_t     p_reg;
    logic [SIDE_W-1:0]  side1_reg, side2_reg, side3_reg;
    logic               v1_reg, v2_reg, v3_reg;

    assign ah = signed'({(A_SIGNED ? a[63] : 1'b0), a[63:32]});
    assign al = signed'({1'b0, a[31:0]});
    assign bh = signed'({(B_SIGNED ? b[63] : 1'b0), b[63:32]});
    assign bl = signed'({1'b0, b[31:0]});

    assign hh_next = ah * bh;
    assign hl_next = ah * bl;
    assign lh_next = al * bh;
    assign ll_next = a[31:0] * b[31:0];

    // weighted sum of the partial products, exact mod 2^128
    assign sum_next = ({{62{hh2_reg[65]}}, hh2_reg} << 64)
                    + ({{61{mid2_reg[66]}}, mid2_reg} << 32)
                    + {64'b0, ll2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hh1_reg   <= hh_next;
            hl1_reg   <= hl_next;
            lh1_reg   <= lh_next;
            ll1_reg   <= ll_next;
            side1_reg <= side_in;
            hh2_reg   <= hh1_reg;
            mid2_reg  <= 67'(hl1_reg) + 67'(lh1_reg);
            ll2_reg   <= ll1_reg;
            side2_reg <= side1_reg;
            p_reg     <= sum_next[SHIFT +: 64];
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign p         = p_reg;
    assign side_out  = side3_reg;

endmodule

FILE: design/gsa_sincos.sv
// gsa_sincos: pipelined sine and cosine of a Q0.64 turn angle, octant fold
// and eight taylor terms per series; uses gsa_pkg and gsa_mul
`timescale 1ns / 1ps

module gsa_sincos #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  gsa_pkg::word_t    angle,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output gsa_pkg::word_t    sn,
    output gsa_pkg::word_t    cs,
    output logic [SIDE_W-1:0] side_out
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    gsa_pkg::word_t    rr;
    logic              swap_next;
    gsa_pkg::word_t    rf_reg;
    logic [1:0]        q0_reg;
    logic              swap0_reg;
    logic [SIDE_W-1:0] side0_reg;
    logic              v0_reg;

    gsa_pkg::word_t    xm, x2m;
    logic [SIDE_W+2:0] sx;
    logic [SIDE_W+66:0] sx2;
    logic              vx, vx2;

    gsa_pkg::word_t    x2_a [0:8];
    gsa_pkg::word_t    s_a  [0:8];
    gsa_pkg::word_t    c_a  [0:8];
    gsa_pkg::word_t    ts_a [0:8];
    gsa_pkg::word_t    tc_a [0:8];
    logic [1:0]        q_a  [0:8];
    logic              sw_a [0:8];
    logic [SIDE_W-1:0] sd_a [0:8];
    logic              v_a  [0:8];

    gsa_pkg::word_t    u_val, v_val;
    gsa_pkg::word_t    sn_reg, cs_reg;
    logic [SIDE_W-1:0] sdo_reg;
    logic              vo_reg;

    // fold into the first octant
    assign rr        = {2'b00, angle[61:0]};
    assign swap_next = rr > gsa_pkg::EIGHTH;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rf_reg    <= swap_next ? gsa_pkg::ONE_Q62 - rr : rr;
            q0_reg    <= angle[63:62];
            swap0_reg <= swap_next;
            side0_reg <= side_in;
        end
    end

    // turns to radians
    gsa_mul #(.A_SIGNED(1'b0), .B_SIGNED(1'b0), .SHIFT(63), .SIDE_W(SIDE_W + 3)) u_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0_reg),
        .a(rf_reg), .b(gsa_pkg::PI_Q62), .side_in({q0_reg, swap0_reg, side0_reg}),
        .out_valid(vx), .p(xm), .side_out(sx)
    );

    gsa_mul #(.A_SIGNED(1'b0), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(SIDE_W + 67)) u_x2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vx),
        .a(xm), .b(xm), .side_in({xm, sx}),
        .out_valid(vx2), .p(x2m), .side_out(sx2)
    );

    assign x2_a[0] = x2m;
    assign s_a[0]  = sx2[SIDE_W+3 +: 64];
    assign ts_a[0] = sx2[SIDE_W+3 +: 64];
    assign c_a[0]  = gsa_pkg::ONE_Q62;
    assign tc_a[0] = gsa_pkg::ONE_Q62;
    assign q_a[0]  = sx2[SIDE_W+1 +: 2];
    assign sw_a[0] = sx2[SIDE_W];
    assign sd_a[0] = sx2[SIDE_W-1:0];
    assign v_a[0]  = vx2;

    for (genvar i = 0; i < 8; i++) begin : g_term
        localparam logic [9:0]   DS  = gsa_pkg::sin_div(i + 1);
        localparam logic [9:0]   DC  = gsa_pkg::cos_div(i + 1);
        localparam gsa_pkg::word_t RS = gsa_pkg::frac_q64(64'd1, {54'b0, DS});
        localparam gsa_pkg::word_t RC = gsa_pkg::frac_q64(64'd1, {54'b0, DC});
        localparam bit SUB = (i % 2) == 0;

        gsa_pkg::word_t      ps, pc, qes, qec;
        logic [SIDE_W+127:0] ss1;
        logic [SIDE_W+191:0] ss2;
        logic [66:0]         sc1;
        logic [130:0]        sc2;
        logic                vs1, vs2;
        logic [19:0]         prd_s, prd_c;
        logic [9:0]          rem_s, rem_c;
        logic                bs, bc;
        gsa_pkg::word_t      ts_next, tc_next;
        gsa_pkg::word_t      x2_reg, s_reg, c_reg, ts_reg, tc_reg;
        logic [1:0]          q_reg;
        logic                sw_reg;
        logic [SIDE_W-1:0]   sd_reg;
        logic                v_reg;

        gsa_mul #(.A_SIGNED(1'b0), .B_SIGNED(1'b0), .SHIFT(62),
                  .SIDE_W(SIDE_W + 128)) u_ms (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_a[i]),
            .a(ts_a[i]), .b(x2_a[i]), .side_in({x2_a[i], s_a[i], sd_a[i]}),
            .out_valid(vs1), .p(ps), .side_out(ss1)
        );

        gsa_mul #(.A_SIGNED(1'b0), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(67)) u_mc (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_a[i]),
            .a(tc_a[i]), .b(x2_a[i]), .side_in({c_a[i], q_a[i], sw_a[i]}),
            .out_valid(), .p(pc), .side_out(sc1)
        );

        // quotient estimate by reciprocal, low by at most one
        gsa_mul #(.A_SIGNED(1'b0), .B_SIGNED(1'b0), .SHIFT(64),
                  .SIDE_W(SIDE_W + 192)) u_rs (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vs1),
            .a(ps), .b(RS), .side_in({ps, ss1}),
            .out_valid(vs2), .p(qes), .side_out(ss2)
        );

        gsa_mul #(.A_SIGNED(1'b0), .B_SIGNED(1'b0), .SHIFT(64), .SIDE_W(131)) u_rc (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vs1),
            .a(pc), .b(RC), .side_in({pc, sc1}),
            .out_valid(), .p(qec), .side_out(sc2)
        );

        // remainder is below twice the divisor, so ten bits settle it
        assign prd_s   = qes[9:0] * DS;
        assign prd_c   = qec[9:0] * DC;
        assign rem_s   = ss2[SIDE_W+128 +: 10] - prd_s[9:0];
        assign rem_c   = sc2[67 +: 10] - prd_c[9:0];
        assign bs      = rem_s >= DS;
        assign bc      = rem_c >= DC;
        assign ts_next = qes + {63'b0, bs};
        assign tc_next = qec + {63'b0, bc};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= vs2;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x2_reg <= ss2[SIDE_W+64 +: 64];
                s_reg  <= SUB ? ss2[SIDE_W +: 64] - ts_next : ss2[SIDE_W +: 64] + ts_next;
                c_reg  <= SUB ? sc2[3 +: 64] - tc_next : sc2[3 +: 64] + tc_next;
                ts_reg <= ts_next;
                tc_reg <= tc_next;
                q_reg  <= sc2[1 +: 2];
                sw_reg <= sc2[0];
                sd_reg <= ss2[SIDE_W-1:0];
            end
        end

        assign x2_a[i+1] = x2_reg;
        assign s_a[i+1]  = s_reg;
        assign c_a[i+1]  = c_reg;
        assign ts_a[i+1] = ts_reg;
        assign tc_a[i+1] = tc_reg;
        assign q_a[i+1]  = q_reg;
        assign sw_a[i+1] = sw_reg;
        assign sd_a[i+1] = sd_reg;
        assign v_a[i+1]  = v_reg;
    end

    // unfold octant and quadrant
    assign u_val = sw_a[8] ? c_a[8] : s_a[8];
    assign v_val = sw_a[8] ? s_a[8] : c_a[8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_a[8];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sdo_reg <= sd_a[8];
            case (q_a[8])
                QUAD_0: begin
                    sn_reg <= u_val;
                    cs_reg <= v_val;
                end
                QUAD_1: begin
                    sn_reg <= v_val;
                    cs_reg <= 64'd0 - u_val;
                end
                QUAD_2: begin
                    sn_reg <= 64'd0 - u_val;
                    cs_reg <= 64'd0 - v_val;
                end
                default: begin
                    sn_reg <= 64'd0 - v_val;
                    cs_reg <= u_val;
                end
            endcase
        end
    end

    assign out_valid = vo_reg;
    assign sn        = sn_reg;
    assign cs        = cs_reg;
    assign side_out  = sdo_reg;

endmodule

FILE: design/greenwich_sidereal_angle.sv
// greenwich_sidereal_angle: julian date in, apparent sidereal binary angle out
// depends on gsa_pkg, gsa_mul and gsa_sincos
`timescale 1ns / 1ps

//  channel | ports                               | carries
//  --------+-------------------------------------+------------------------------
//  input   | s_valid s_ready s_julian_date[53:0] | julian date, unsigned Q(54-F).F
//  result  | m_valid m_ready m_hour_angle        | sidereal angle, 2^ANGLE_BITS/turn
//
//  one request enters per cycle unless a held result stalls the pipe; each result
//  passes through the two 64-stage sine/cosine pipelines in series
//  synchronous active-low reset clears only the valid bits
//  a held result stalls every stage at once; nothing is dropped or repeated

module greenwich_sidereal_angle #(
    parameter int ANGLE_BITS         = 32,
    parameter int DATE_FRACTION_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [53:0]           s_julian_date,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ANGLE_BITS-1:0] m_hour_angle
);

    localparam int F = DATE_FRACTION_BITS;

    // global advance: the whole pipe moves unless the result is held
    logic ce;

    // input stage
    gsa_pkg::word_t dq_reg, g0_reg;
    logic           v0_reg;

    // date products
    gsa_pkg::word_t t1m, lm, lpm, ndm, gm;
    gsa_pkg::word_t g0d;
    logic           vg1;

    gsa_pkg::word_t l1_reg, lp1_reg, nd1_reg, t1_reg, gp1_reg;
    logic           v1_reg;

    // powers of T
    gsa_pkg::word_t t2m, t3m;
    logic [319:0]   sa;
    logic [383:0]   sb;
    logic           vt2, vt3;

    // obliquity and sidereal polynomial terms
    gsa_pkg::word_t e1m, e2m, e3m, g2m, g3m;
    logic [255:0]   se;
    logic           ve;

    gsa_pkg::word_t eps0_2_reg, gmst2_reg, l2_reg, lp2_reg, nd2_reg;
    logic           v2_reg;

    // nutation arguments
    gsa_pkg::word_t sn0, cs0, sn1, cs1, sn2, cs2, sn3, cs3;
    logic [127:0]   ssc;
    logic           vsc;

    gsa_pkg::word_t p0m, p1m, p2m, p3m, d0m, d1m, d2m, d3m;
    logic [127:0]   sp;
    logic           vp;

    gsa_pkg::word_t dpsi3_reg, deps3_reg, eps03_reg, gmst3_reg;
    logic           v3_reg;
    gsa_pkg::word_t eps4_reg, dpsi4_reg, gmst4_reg;
    logic           v4_reg;

    // true obliquity and equation of the equinoxes
    gsa_pkg::word_t cse;
    logic [127:0]   sse;
    logic           vse;

    gsa_pkg::word_t eqm, gmstf;
    logic           vf;
    gsa_pkg::word_t gst;

    logic [ANGLE_BITS-1:0] ha_reg;
    logic                  mv_reg;

    assign ce      = !mv_reg || m_ready;
    assign s_ready = ce;

    // days from J2000; the sidereal day-count term is jd shifted into turns,
    // the J2000 offset falls out above bit 63
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (ce) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dq_reg <= 64'(s_julian_date) - (64'(gsa_pkg::J2000_DAY) << F);
            g0_reg <= gsa_pkg::K_G0 + (64'(s_julian_date) << (64 - F));
        end
    end

    // centuries and linear parts of the fundamental arguments
    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(F + 24), .SIDE_W(1)) u_t1 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v0_reg),
        .a(dq_reg), .b(gsa_pkg::K_T), .side_in(1'b0),
        .out_valid(), .p(t1m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(F), .SIDE_W(1)) u_l (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v0_reg),
        .a(dq_reg), .b(gsa_pkg::K_LR), .side_in(1'b0),
        .out_valid(), .p(lm), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(F), .SIDE_W(1)) u_lp (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v0_reg),
        .a(dq_reg), .b(gsa_pkg::K_LPR), .side_in(1'b0),
        .out_valid(), .p(lpm), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(F), .SIDE_W(1)) u_nd (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v0_reg),
        .a(dq_reg), .b(gsa_pkg::K_NR), .side_in(1'b0),
        .out_valid(), .p(ndm), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(F), .SIDE_W(64)) u_g (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v0_reg),
        .a(dq_reg), .b(gsa_pkg::K_GR), .side_in(g0_reg),
        .out_valid(vg1), .p(gm), .side_out(g0d)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= vg1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            l1_reg  <= gsa_pkg::K_L0 + lm;
            lp1_reg <= gsa_pkg::K_LP0 + lpm;
            nd1_reg <= gsa_pkg::K_N0 - ndm;
            t1_reg  <= t1m;
            gp1_reg <= g0d + gm;
        end
    end

    // T^2 then T^3, arguments ride along
    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b1), .SHIFT(40), .SIDE_W(320)) u_t2 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v1_reg),
        .a(t1_reg), .b(t1_reg), .side_in({t1_reg, gp1_reg, l1_reg, lp1_reg, nd1_reg}),
        .out_valid(vt2), .p(t2m), .side_out(sa)
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b1), .SHIFT(40), .SIDE_W(384)) u_t3 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vt2),
        .a(t2m), .b(sa[256 +: 64]), .side_in({t2m, sa}),
        .out_valid(vt3), .p(t3m), .side_out(sb)
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(40), .SIDE_W(256)) u_e1 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vt3),
        .a(sb[256 +: 64]), .b(gsa_pkg::K_E1), .side_in(sb[255:0]),
        .out_valid(ve), .p(e1m), .side_out(se)
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(40), .SIDE_W(1)) u_e2 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vt3),
        .a(sb[320 +: 64]), .b(gsa_pkg::K_E2), .side_in(1'b0),
        .out_valid(), .p(e2m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(40), .SIDE_W(1)) u_e3 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vt3),
        .a(t3m), .b(gsa_pkg::K_E3), .side_in(1'b0),
        .out_valid(), .p(e3m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(40), .SIDE_W(1)) u_g2 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vt3),
        .a(sb[320 +: 64]), .b(gsa_pkg::K_G2), .side_in(1'b0),
        .out_valid(), .p(g2m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(40), .SIDE_W(1)) u_g3 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vt3),
        .a(t3m), .b(gsa_pkg::K_G3), .side_in(1'b0),
        .out_valid(), .p(g3m), .side_out()
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= ve;
        end
    end

    // mean obliquity and mean sidereal angle
    always_ff @(posedge aclk) begin
        if (ce) begin
            eps0_2_reg <= gsa_pkg::K_E0 - e1m - e2m + e3m;
            gmst2_reg  <= se[192 +: 64] + g2m - g3m;
            l2_reg     <= se[128 +: 64];
            lp2_reg    <= se[64 +: 64];
            nd2_reg    <= se[0 +: 64];
        end
    end

    // four nutation arguments: node, twice solar, twice lunar, twice node
    gsa_sincos #(.SIDE_W(128)) u_sc0 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v2_reg),
        .angle(nd2_reg), .side_in({eps0_2_reg, gmst2_reg}),
        .out_valid(vsc), .sn(sn0), .cs(cs0), .side_out(ssc)
    );

    gsa_sincos #(.SIDE_W(1)) u_sc1 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v2_reg),
        .angle(l2_reg << 1), .side_in(1'b0),
        .out_valid(), .sn(sn1), .cs(cs1), .side_out()
    );

    gsa_sincos #(.SIDE_W(1)) u_sc2 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v2_reg),
        .angle(lp2_reg << 1), .side_in(1'b0),
        .out_valid(), .sn(sn2), .cs(cs2), .side_out()
    );

    gsa_sincos #(.SIDE_W(1)) u_sc3 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v2_reg),
        .angle(nd2_reg << 1), .side_in(1'b0),
        .out_valid(), .sn(sn3), .cs(cs3), .side_out()
    );

    // series coefficients times signed trig values
    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(128)) u_p0 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vsc),
        .a(sn0), .b(gsa_pkg::C_DPSI0), .side_in(ssc),
        .out_valid(vp), .p(p0m), .side_out(sp)
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(1)) u_p1 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vsc),
        .a(sn1), .b(gsa_pkg::C_DPSI1), .side_in(1'b0),
        .out_valid(), .p(p1m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(1)) u_p2 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vsc),
        .a(sn2), .b(gsa_pkg::C_DPSI2), .side_in(1'b0),
        .out_valid(), .p(p2m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(1)) u_p3 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vsc),
        .a(sn3), .b(gsa_pkg::C_DPSI3), .side_in(1'b0),
        .out_valid(), .p(p3m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(1)) u_d0 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vsc),
        .a(cs0), .b(gsa_pkg::C_DEPS0), .side_in(1'b0),
        .out_valid(), .p(d0m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(1)) u_d1 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vsc),
        .a(cs1), .b(gsa_pkg::C_DEPS1), .side_in(1'b0),
        .out_valid(), .p(d1m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(1)) u_d2 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vsc),
        .a(cs2), .b(gsa_pkg::C_DEPS2), .side_in(1'b0),
        .out_valid(), .p(d2m), .side_out()
    );

    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b0), .SHIFT(62), .SIDE_W(1)) u_d3 (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vsc),
        .a(cs3), .b(gsa_pkg::C_DEPS3), .side_in(1'b0),
        .out_valid(), .p(d3m), .side_out()
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= vp;
            v4_reg <= v3_reg;
        end
    end

    // nutation sums, then true obliquity
    always_ff @(posedge aclk) begin
        if (ce) begin
            dpsi3_reg <= 64'd0 - p0m - p1m - p2m + p3m;
            deps3_reg <= d0m + d1m + d2m - d3m;
            eps03_reg <= sp[64 +: 64];
            gmst3_reg <= sp[0 +: 64];
            eps4_reg  <= eps03_reg + deps3_reg;
            dpsi4_reg <= dpsi3_reg;
            gmst4_reg <= gmst3_reg;
        end
    end

    gsa_sincos #(.SIDE_W(128)) u_sce (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(v4_reg),
        .angle(eps4_reg), .side_in({dpsi4_reg, gmst4_reg}),
        .out_valid(vse), .sn(), .cs(cse), .side_out(sse)
    );

    // equation of the equinoxes: dpsi * cos(eps)
    gsa_mul #(.A_SIGNED(1'b1), .B_SIGNED(1'b1), .SHIFT(62), .SIDE_W(64)) u_eq (
        .aclk(aclk), .aresetn(aresetn), .en(ce), .in_valid(vse),
        .a(sse[64 +: 64]), .b(cse), .side_in(sse[0 +: 64]),
        .out_valid(vf), .p(eqm), .side_out(gmstf)
    );

    assign gst = gmstf + eqm;

    // output register, top bits of the turn value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (ce) begin
            mv_reg <= vf;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ha_reg <= gst[63 -: ANGLE_BITS];
        end
    end

    assign m_valid      = mv_reg;
    assign m_hour_angle = ha_reg;

`ifndef ASSERT_OFF
    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a new result must come from the last multiply stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(vf))
        else $error("result appeared without a finished request behind it");

    // a stalled pipe keeps its first stage frozen
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(v0_reg))
        else $error("input stage moved during a stall");
`endif

endmodule
